@@ rtl/core/calendar_date_subtractor_assert.svh @@
// Assertion macros for the checker file of the date subtractor.
`ifndef CALENDAR_DATE_SUBTRACTOR_ASSERT_SVH
`define CALENDAR_DATE_SUBTRACTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cds_checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define CDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cds_checker: next-cycle property failed");

`endif

@@ rtl/core/cds_pkg.sv @@
`timescale 1ns / 1ps
// Package for the date subtractor: payload types, microcode table and calendar helpers.
package cds_pkg;

  localparam int YearBits      = 16;
  localparam int CountW        = 16;
  localparam int RemW          = 19;  // holds the count of weeks times seven
  localparam int ScaleW        = 10;
  localparam int ProdW         = 26;  // holds the count times one thousand
  localparam int DiffW         = 28;
  localparam int UpcW          = 4;
  localparam int MonthsPerYear = 12;
  localparam int Fold25Max     = 45;

  localparam logic [YearBits-1:0] YearLowPat = {1'b1, {(YearBits-1){1'b0}}};
  localparam logic [YearBits-1:0] YearOne    = YearBits'(1);
  localparam logic signed [DiffW-1:0] YearMin = -(DiffW'(1) <<< (YearBits-1));

  // Unit codes.
  localparam logic [2:0] OpDays      = 3'd0;
  localparam logic [2:0] OpWeeks     = 3'd1;
  localparam logic [2:0] OpMonths    = 3'd2;
  localparam logic [2:0] OpYears     = 3'd3;
  localparam logic [2:0] OpDecades   = 3'd4;
  localparam logic [2:0] OpCenturies = 3'd5;
  localparam logic [2:0] OpMillennia = 3'd6;

  // Jump conditions of a control word.
  localparam logic [2:0] CondNone     = 3'd0;
  localparam logic [2:0] CondAlways   = 3'd1;
  localparam logic [2:0] CondBad      = 3'd2;
  localparam logic [2:0] CondOpDays   = 3'd3;
  localparam logic [2:0] CondOpMonths = 3'd4;
  localparam logic [2:0] CondOpYears  = 3'd5;
  localparam logic [2:0] CondDayFits  = 3'd6;
  localparam logic [2:0] CondRemZero  = 3'd7;

  // Datapath actions of a control word.
  localparam logic [3:0] ActNone     = 4'd0;
  localparam logic [3:0] ActSetup    = 4'd1;
  localparam logic [3:0] ActDayBack  = 4'd2;
  localparam logic [3:0] ActDayLen   = 4'd3;
  localparam logic [3:0] ActDayFin   = 4'd4;
  localparam logic [3:0] ActMonBack  = 4'd5;
  localparam logic [3:0] ActMonClamp = 4'd6;
  localparam logic [3:0] ActYear     = 4'd7;
  localparam logic [3:0] ActPublish  = 4'd8;

  // Microprogram addresses.
  localparam logic [UpcW-1:0] UpcIdle     = 4'd0;
  localparam logic [UpcW-1:0] UpcCheck    = 4'd1;
  localparam logic [UpcW-1:0] UpcSetup    = 4'd2;
  localparam logic [UpcW-1:0] UpcSelMon   = 4'd3;
  localparam logic [UpcW-1:0] UpcSelYear  = 4'd4;
  localparam logic [UpcW-1:0] UpcNoOp     = 4'd5;
  localparam logic [UpcW-1:0] UpcDayTest  = 4'd6;
  localparam logic [UpcW-1:0] UpcDayBack  = 4'd7;
  localparam logic [UpcW-1:0] UpcDayLen   = 4'd8;
  localparam logic [UpcW-1:0] UpcDayFin   = 4'd9;
  localparam logic [UpcW-1:0] UpcMonTest  = 4'd10;
  localparam logic [UpcW-1:0] UpcMonBack  = 4'd11;
  localparam logic [UpcW-1:0] UpcMonClamp = 4'd12;
  localparam logic [UpcW-1:0] UpcYear     = 4'd13;
  localparam logic [UpcW-1:0] UpcDone     = 4'd14;

  typedef struct packed {
    logic [2:0]                 unit_op;
    logic [CountW-1:0]          step_count;
    logic [4:0]                 in_day;
    logic [3:0]                 in_month;
    logic signed [YearBits-1:0] in_year;
  } cds_req_t;

  typedef struct packed {
    logic [4:0]                 out_day;
    logic [3:0]                 out_month;
    logic signed [YearBits-1:0] out_year;
    logic                       year_wrapped;
    logic                       bad_date;
  } cds_res_t;

  typedef struct packed {
    logic [2:0]      cond;
    logic [3:0]      act;
    logic [UpcW-1:0] target;
  } cds_ucode_t;

  typedef struct packed {
    logic bad;
    logic op_days;
    logic op_months;
    logic op_years;
    logic day_fits;
    logic rem_zero;
  } cds_status_t;

  // When the condition fails, the sequencer falls through to the next address.
  function automatic cds_ucode_t ucode_rom(input logic [UpcW-1:0] addr);
    cds_ucode_t w;
    w = '{CondAlways, ActNone, UpcIdle};
    case (addr)
      UpcCheck:    w = '{CondBad,      ActNone,     UpcDone};
      UpcSetup:    w = '{CondOpDays,   ActSetup,    UpcDayTest};
      UpcSelMon:   w = '{CondOpMonths, ActNone,     UpcMonTest};
      UpcSelYear:  w = '{CondOpYears,  ActNone,     UpcYear};
      UpcNoOp:     w = '{CondAlways,   ActNone,     UpcDone};
      UpcDayTest:  w = '{CondDayFits,  ActNone,     UpcDayFin};
      UpcDayBack:  w = '{CondNone,     ActDayBack,  UpcIdle};
      UpcDayLen:   w = '{CondAlways,   ActDayLen,   UpcDayTest};
      UpcDayFin:   w = '{CondAlways,   ActDayFin,   UpcDone};
      UpcMonTest:  w = '{CondRemZero,  ActNone,     UpcDone};
      UpcMonBack:  w = '{CondNone,     ActMonBack,  UpcIdle};
      UpcMonClamp: w = '{CondAlways,   ActMonClamp, UpcMonTest};
      UpcYear:     w = '{CondAlways,   ActYear,     UpcDone};
      UpcDone:     w = '{CondAlways,   ActPublish,  UpcIdle};
      default:     w = '{CondAlways,   ActNone,     UpcIdle};
    endcase
    return w;
  endfunction

  function automatic logic [ScaleW-1:0] unit_scale(input logic [2:0] op);
    logic [ScaleW-1:0] s;
    case (op)
      OpYears:     s = ScaleW'(1);
      OpDecades:   s = ScaleW'(10);
      OpCenturies: s = ScaleW'(100);
      OpMillennia: s = ScaleW'(1000);
      default:     s = '0;
    endcase
    return s;
  endfunction

  // Since 1024 is -1 modulo 25 and 65536 is 11 modulo 25, the signed year folds
  // into a small positive value with the same residue.
  function automatic logic div_by_25(input logic [YearBits-1:0] y);
    logic [10:0] t;
    logic        hit;
    t = 11'(y[9:0]) + 11'd100 - 11'(y[15:10]) - (y[15] ? 11'd11 : 11'd0);
    hit = 1'b0;
    for (int k = 0; k <= Fold25Max; k++) begin
      if (t == 11'(k * 25)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_leap(input logic [YearBits-1:0] y);
    logic d25;
    d25 = div_by_25(y);
    return ((y[3:0] == 4'd0) && d25) || ((y[1:0] == 2'd0) && !d25);
  endfunction

  function automatic logic [4:0] month_len(input logic [YearBits-1:0] y,
                                           input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                     len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/calendar_date_subtractor.sv @@
`timescale 1ns / 1ps
// Top level of the date subtractor: datapath driven by the microcode sequencer.
//
//   channel   direction  handshake                 payload
//   request   in         start high, busy low      req_i  (cds_req_t)
//   result    out        res_valid_o, one cycle    res_o  (cds_res_t)
//
// A flagged date goes from the check step straight to the result step, year-type
// units and the unused code pass the setup and unit selection steps, and day, week
// and month units loop over the months crossed, since the sequencer spends three
// steps on each month; the result strobe comes in the cycle after the last step.
// Reset only clears the step counter and the strobe.
// The strobe is not held: it is shown for one cycle, and busy blocks new items.
module calendar_date_subtractor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cds_pkg::cds_req_t req_i,
  output logic              res_valid_o,
  output cds_pkg::cds_res_t res_o
);

  localparam int YB = cds_pkg::YearBits;
  localparam int RW = cds_pkg::RemW;
  localparam int PW = cds_pkg::ProdW;
  localparam int DW = cds_pkg::DiffW;

  cds_pkg::cds_ucode_t  cw;
  cds_pkg::cds_status_t status;
  logic                 accept;

  logic [4:0]                 d_q, d_d;
  logic [3:0]                 m_q, m_d;
  logic signed [YB-1:0]       y_q, y_d;
  logic [RW-1:0]              rem_q, rem_d;
  logic [PW-1:0]              prod_q, prod_d;
  logic [2:0]                 op_q, op_d;
  logic [cds_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                       wrap_q, wrap_d;
  cds_pkg::cds_res_t          res_q, res_d;
  logic                       res_valid_q, res_valid_d;

  logic [3:0]           prev_m;
  logic signed [YB-1:0] prev_y;
  logic                 prev_wrap;
  logic [4:0]           cur_len;
  logic signed [DW-1:0] year_diff;

  cds_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (accept),
    .status_i (status),
    .ucode_o  (cw),
    .busy_o   (busy)
  );

  assign accept = start && !busy;

  always_comb begin
    status.bad       = (m_q == 4'd0) || (m_q > 4'(cds_pkg::MonthsPerYear)) || (d_q == 5'd0);
    status.op_days   = (op_q == cds_pkg::OpDays) || (op_q == cds_pkg::OpWeeks);
    status.op_months = (op_q == cds_pkg::OpMonths);
    status.op_years  = (op_q == cds_pkg::OpYears) || (op_q == cds_pkg::OpDecades) ||
                       (op_q == cds_pkg::OpCenturies) || (op_q == cds_pkg::OpMillennia);
    status.day_fits  = (RW'(d_q) > rem_q);
    status.rem_zero  = (rem_q == '0);
  end

  // Going back from January lands on December of the previous year.
  always_comb begin
    if (m_q == 4'd1) begin
      prev_m    = 4'(cds_pkg::MonthsPerYear);
      prev_y    = y_q - cds_pkg::YearOne;
      prev_wrap = (y_q == cds_pkg::YearLowPat);
    end else begin
      prev_m    = m_q - 4'd1;
      prev_y    = y_q;
      prev_wrap = 1'b0;
    end
  end

  assign cur_len   = cds_pkg::month_len(y_q, m_q);
  assign year_diff = $signed(DW'(y_q)) - $signed(DW'(prod_q));

  always_comb begin
    d_d         = d_q;
    m_d         = m_q;
    y_d         = y_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    wrap_d      = wrap_q;
    res_d       = res_q;
    res_valid_d = 1'b0;

    if (accept) begin
      d_d    = req_i.in_day;
      m_d    = req_i.in_month;
      y_d    = req_i.in_year;
      op_d   = req_i.unit_op;
      cnt_d  = req_i.step_count;
      wrap_d = 1'b0;
    end

    case (cw.act)
      cds_pkg::ActSetup: begin
        rem_d  = (op_q == cds_pkg::OpWeeks) ? (RW'(cnt_q) << 3) - RW'(cnt_q) : RW'(cnt_q);
        prod_d = PW'(cnt_q) * PW'(cds_pkg::unit_scale(op_q));
      end
      cds_pkg::ActDayBack: begin
        rem_d  = rem_q - RW'(d_q);
        m_d    = prev_m;
        y_d    = prev_y;
        wrap_d = wrap_q | prev_wrap;
      end
      cds_pkg::ActDayLen: begin
        d_d = cur_len;
      end
      cds_pkg::ActDayFin: begin
        d_d = d_q - rem_q[4:0];
      end
      cds_pkg::ActMonBack: begin
        rem_d  = rem_q - RW'(1);
        m_d    = prev_m;
        y_d    = prev_y;
        wrap_d = wrap_q | prev_wrap;
      end
      cds_pkg::ActMonClamp: begin
        if (d_q > cur_len) d_d = cur_len;
      end
      cds_pkg::ActYear: begin
        y_d = year_diff[YB-1:0];
        if (year_diff < cds_pkg::YearMin) wrap_d = 1'b1;
      end
      cds_pkg::ActPublish: begin
        res_d.out_day      = d_q;
        res_d.out_month    = m_q;
        res_d.out_year     = y_q;
        res_d.year_wrapped = wrap_q;
        res_d.bad_date     = status.bad;
        res_valid_d        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    op_q   <= op_d;
    cnt_q  <= cnt_d;
    wrap_q <= wrap_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/cds_seq.sv @@
`timescale 1ns / 1ps
// Microcode sequencer of the date subtractor: step counter, control table and jumps.
module cds_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  cds_pkg::cds_status_t     status_i,
  output cds_pkg::cds_ucode_t      ucode_o,
  output logic                     busy_o
);

  logic [cds_pkg::UpcW-1:0] upc_q, upc_d;
  cds_pkg::cds_ucode_t      cw;
  logic                     hit;

  assign cw = cds_pkg::ucode_rom(upc_q);

  always_comb begin
    case (cw.cond)
      cds_pkg::CondNone:     hit = 1'b0;
      cds_pkg::CondAlways:   hit = 1'b1;
      cds_pkg::CondBad:      hit = status_i.bad;
      cds_pkg::CondOpDays:   hit = status_i.op_days;
      cds_pkg::CondOpMonths: hit = status_i.op_months;
      cds_pkg::CondOpYears:  hit = status_i.op_years;
      cds_pkg::CondDayFits:  hit = status_i.day_fits;
      cds_pkg::CondRemZero:  hit = status_i.rem_zero;
      default:               hit = 1'b0;
    endcase
  end

  always_comb begin
    if (upc_q == cds_pkg::UpcIdle) begin
      upc_d = go_i ? cds_pkg::UpcCheck : cds_pkg::UpcIdle;
    end else if (hit) begin
      upc_d = cw.target;
    end else begin
      upc_d = upc_q + cds_pkg::UpcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= cds_pkg::UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ucode_o = cw;
  assign busy_o  = (upc_q != cds_pkg::UpcIdle);

endmodule

@@ rtl/core/cds_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker of the date subtractor and its bind to the top level.
`include "calendar_date_subtractor_assert.svh"

module cds_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input logic              res_valid_i,
  input cds_pkg::cds_res_t res_i
);

  logic res_in_range;

  assign res_in_range = (res_i.out_month != 4'd0) &&
                        (res_i.out_month <= 4'(cds_pkg::MonthsPerYear)) &&
                        (res_i.out_day != 5'd0);

  // Each item yields a single one-cycle strobe, never two in a row.
  `CDS_ASSERT_NEXT(a_strobe_single, res_valid_i, !res_valid_i)
  `CDS_ASSERT_NEXT(a_accept_busy, start_i && !busy_i, busy_i)
  `CDS_ASSERT_NOW(a_strobe_after_busy, res_valid_i, $past(busy_i))
  `CDS_ASSERT_NOW(a_bad_no_wrap, res_valid_i && res_i.bad_date, !res_i.year_wrapped)
  `CDS_ASSERT_NOW(a_date_range, res_valid_i && !res_i.bad_date, res_in_range)

endmodule

bind calendar_date_subtractor cds_checker u_cds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the date subtractor: directed and random dates against a predictor.
module testbench;
  import cds_pkg::*;

  localparam logic [2:0] OpUnused = 3'd7;
  localparam int ResetCycles = 11;
  localparam int PhaseItems = 250;
  localparam int DrainCycles = 16;
  localparam int CycleLimit = 150_000_000;
  localparam int PrintLimit = 100;

  // Predicts the moved-back date of every accepted item and checks the results in order.
  class date_scoreboard;
    cds_res_t pending_dates[$];
    int errors;
    int results_seen;

    function new();
      errors = 0;
      results_seen = 0;
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= PrintLimit) begin
        $display("mismatch at %0t: %s", $realtime, what);
      end
    endtask

    function longint fold_year(input longint v, inout bit wrapped);
      logic signed [YearBits-1:0] t;
      if (v < -(longint'(1) <<< (YearBits - 1))) wrapped = 1'b1;
      t = v[YearBits-1:0];
      return longint'(t);
    endfunction

    function bit leap_year(input longint y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function longint days_in_month(input longint y, input longint m);
      if (m == 2) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function void month_back(inout longint m, inout longint y, inout bit wrapped);
      if (m == 1) begin
        m = MonthsPerYear;
        y = fold_year(y - 1, wrapped);
      end else begin
        m = m - 1;
      end
    endfunction

    function cds_res_t step_back_date(input cds_req_t r);
      longint d, m, y, rem, len, scale;
      bit wrapped, bad;
      cds_res_t res;
      d = r.in_day;
      m = r.in_month;
      y = longint'($signed(r.in_year));
      wrapped = 1'b0;
      bad = 1'b0;
      if (m < 1 || m > MonthsPerYear || d < 1) begin
        bad = 1'b1;
      end else begin
        case (r.unit_op)
          OpDays, OpWeeks: begin
            rem = (r.unit_op == OpWeeks) ? longint'(r.step_count) * 7 : longint'(r.step_count);
            // Whole months are consumed at once; stepping past day 1 lands on the
            // last day of the previous month.
            while (rem > 0) begin
              if (d > rem) begin
                d -= rem;
                rem = 0;
              end else begin
                rem -= d;
                month_back(m, y, wrapped);
                d = days_in_month(y, m);
              end
            end
          end
          OpMonths: begin
            for (int i = 0; i < int'(r.step_count); i++) begin
              month_back(m, y, wrapped);
              len = days_in_month(y, m);
              if (d > len) d = len;
            end
          end
          OpYears, OpDecades, OpCenturies, OpMillennia: begin
            scale = (r.unit_op == OpYears) ? 1 : (r.unit_op == OpDecades) ? 10 :
                    (r.unit_op == OpCenturies) ? 100 : 1000;
            y = fold_year(y - longint'(r.step_count) * scale, wrapped);
          end
          default: begin
          end
        endcase
      end
      res.out_day = d[4:0];
      res.out_month = m[3:0];
      res.out_year = y[YearBits-1:0];
      res.year_wrapped = wrapped;
      res.bad_date = bad;
      return res;
    endfunction

    function void note_request(input cds_req_t r);
      pending_dates.push_back(step_back_date(r));
    endfunction

    task check_result(input cds_res_t got);
      cds_res_t want;
      results_seen++;
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item outstanding", results_seen));
      end else begin
        want = pending_dates.pop_front();
        if (got.out_day !== want.out_day)
          report_mismatch($sformatf("result %0d out_day: got %0d, expected %0d",
                                    results_seen, got.out_day, want.out_day));
        if (got.out_month !== want.out_month)
          report_mismatch($sformatf("result %0d out_month: got %0d, expected %0d",
                                    results_seen, got.out_month, want.out_month));
        if (got.out_year !== want.out_year)
          report_mismatch($sformatf("result %0d out_year: got %0d, expected %0d",
                                    results_seen, got.out_year, want.out_year));
        if (got.year_wrapped !== want.year_wrapped)
          report_mismatch($sformatf("result %0d year_wrapped: got %0b, expected %0b",
                                    results_seen, got.year_wrapped, want.year_wrapped));
        if (got.bad_date !== want.bad_date)
          report_mismatch($sformatf("result %0d bad_date: got %0b, expected %0b",
                                    results_seen, got.bad_date, want.bad_date));
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  cds_req_t req_i = '0;
  logic     res_valid_o;
  cds_res_t res_o;
  int       cycle_count = 0;

  date_scoreboard dates = new();

  calendar_date_subtractor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("testbench: done, errors");
    $finish;
  end

  // Results are checked before a new item is noted, so an item accepted at the same
  // edge never stands in for the one being answered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) dates.check_result(res_o);
      if (start && !busy) dates.note_request(req_i);
    end
  end

  function automatic cds_req_t make_date_request(input logic [2:0] op, input int count,
                                                 input int day, input int month,
                                                 input int year);
    cds_req_t r;
    r.unit_op = op;
    r.step_count = count[CountW-1:0];
    r.in_day = day[4:0];
    r.in_month = month[3:0];
    r.in_year = year[YearBits-1:0];
    return r;
  endfunction

  // Day and month units cost cycles per month crossed, so large counts are rare.
  function automatic cds_req_t make_random_request();
    logic [2:0] op;
    int count, day, month, year;
    op = ($urandom_range(99) < 3) ? OpUnused : 3'($urandom_range(6));
    day = $urandom_range(31, 1);
    month = $urandom_range(12, 1);
    if ($urandom_range(99) < 5) begin
      if ($urandom_range(1) == 0) day = 0;
      else month = ($urandom_range(1) == 0) ? 0 : $urandom_range(15, 13);
    end
    case ($urandom_range(3))
      0:       year = $urandom_range(8) - 32768;
      1:       year = $urandom_range(2100, 1500);
      default: year = $urandom_range(65535);
    endcase
    case (op)
      OpDays:   count = ($urandom_range(99) == 0) ? $urandom_range(65535) : $urandom_range(2000);
      OpWeeks:  count = ($urandom_range(99) == 0) ? $urandom_range(65535) : $urandom_range(300);
      OpMonths: count = ($urandom_range(99) == 0) ? $urandom_range(2000) : $urandom_range(48);
      default:  count = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(40);
    endcase
    if ($urandom_range(99) < 4) count = 0;
    return make_date_request(op, count, day, month, year);
  endfunction

  task automatic send_date_request(input cds_req_t item, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // Waits on the clock before the first check, so start is never driven twice in one step.
  task automatic wait_for_results();
    do @(posedge clk_i); while (dates.pending_dates.size() != 0);
  endtask

  initial begin
    cds_req_t directed[$];
    int idle_pct;
    directed.push_back(make_date_request(OpDays, 0, 1, 3, 2024));
    directed.push_back(make_date_request(OpDays, 1, 1, 3, 2024));
    directed.push_back(make_date_request(OpDays, 1, 1, 3, 1900));
    directed.push_back(make_date_request(OpDays, 1, 1, 3, 2000));
    directed.push_back(make_date_request(OpDays, 1, 1, 1, 1));
    directed.push_back(make_date_request(OpDays, 1, 1, 1, -32768));
    directed.push_back(make_date_request(OpDays, 65535, 31, 12, 32767));
    directed.push_back(make_date_request(OpWeeks, 65535, 15, 6, 2024));
    directed.push_back(make_date_request(OpDays, 5, 31, 4, 2023));
    directed.push_back(make_date_request(OpMonths, 1, 31, 3, 2023));
    directed.push_back(make_date_request(OpMonths, 3, 31, 5, 2024));
    directed.push_back(make_date_request(OpMonths, 65535, 31, 12, -30000));
    directed.push_back(make_date_request(OpMonths, 0, 31, 12, 0));
    directed.push_back(make_date_request(OpYears, 65535, 29, 2, 0));
    directed.push_back(make_date_request(OpYears, 1, 1, 1, -32768));
    directed.push_back(make_date_request(OpDecades, 1, 29, 2, 2024));
    directed.push_back(make_date_request(OpCenturies, 327, 31, 12, 32767));
    directed.push_back(make_date_request(OpMillennia, 65535, 1, 1, -32768));
    directed.push_back(make_date_request(OpMillennia, 1, 15, 7, 999));
    directed.push_back(make_date_request(OpUnused, 5, 10, 10, 2020));
    directed.push_back(make_date_request(OpMonths, 65535, 15, 0, 2020));
    directed.push_back(make_date_request(OpDays, 3, 31, 15, -1));
    directed.push_back(make_date_request(OpDays, 3, 20, 13, 5));
    directed.push_back(make_date_request(OpWeeks, 2, 0, 6, 100));
    directed.push_back(make_date_request(OpYears, 0, 31, 12, -1));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_date_request(directed[k], 0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 75 : 26;
      start <= 1'b0;
      wait_for_results();
      repeat (PhaseItems) send_date_request(make_random_request(), idle_pct);
    end

    start <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (dates.pending_dates.size() != 0)
      dates.report_mismatch($sformatf("%0d expected results never arrived",
                                      dates.pending_dates.size()));

    if (dates.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ calendar_date_subtractor.f @@
+incdir+rtl/core
rtl/core/cds_pkg.sv
rtl/core/cds_seq.sv
rtl/core/calendar_date_subtractor.sv
rtl/core/cds_checker.sv
test/testbench.sv
